// ----- rtl/lkh_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and mix step functions for the lookup3 byte key hash
package lkh_pkg;

    localparam logic [31:0] HASH_INIT     = 32'hdeadbeef;
    localparam logic [31:0] MAX_KEY_BYTES = 32'd65535;
    localparam logic [3:0]  BLOCK_BYTES   = 4'd12;
    localparam logic [2:0]  MIX_LAST      = 3'd5;
    localparam logic [2:0]  FIN_LAST      = 3'd6;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } lkh_words_t;

    // one unit of work for the back end
    typedef struct packed {
        logic        init;
        logic [31:0] init_value;
        logic [31:0] k_a;
        logic [31:0] k_b;
        logic [31:0] k_c;
        logic        mix;
        logic [7:0]  tail_byte;
        logic        fin;
        logic        emit;
    } lkh_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_FIN,
        ST_EMIT
    } lkh_state_t;

    function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] k);
        return (x << k) | (x >> (6'd32 - {1'b0, k}));
    endfunction

    // one step of the six-step block mix
    function automatic lkh_words_t mix_step(logic [2:0] step, lkh_words_t w);
        lkh_words_t r;
        r = w;
        unique case (step)
            3'd0:
            begin
                r.a = (w.a - w.c) ^ rotl32(w.c, 5'd4);
                r.c = w.c + w.b;
            end
            3'd1:
            begin
                r.b = (w.b - w.a) ^ rotl32(w.a, 5'd6);
                r.a = w.a + w.c;
            end
            3'd2:
            begin
                r.c = (w.c - w.b) ^ rotl32(w.b, 5'd8);
                r.b = w.b + w.a;
            end
            3'd3:
            begin
                r.a = (w.a - w.c) ^ rotl32(w.c, 5'd16);
                r.c = w.c + w.b;
            end
            3'd4:
            begin
                r.b = (w.b - w.a) ^ rotl32(w.a, 5'd19);
                r.a = w.a + w.c;
            end
            3'd5:
            begin
                r.c = (w.c - w.b) ^ rotl32(w.b, 5'd4);
                r.b = w.b + w.a;
            end
            default:
            begin
                r = w;
            end
        endcase
        return r;
    endfunction

    // one step of the seven-step final mix
    function automatic lkh_words_t fin_step(logic [2:0] step, lkh_words_t w);
        lkh_words_t r;
        r = w;
        unique case (step)
            3'd0: r.c = (w.c ^ w.b) - rotl32(w.b, 5'd14);
            3'd1: r.a = (w.a ^ w.c) - rotl32(w.c, 5'd11);
            3'd2: r.b = (w.b ^ w.a) - rotl32(w.a, 5'd25);
            3'd3: r.c = (w.c ^ w.b) - rotl32(w.b, 5'd16);
            3'd4: r.a = (w.a ^ w.c) - rotl32(w.c, 5'd4);
            3'd5: r.b = (w.b ^ w.a) - rotl32(w.a, 5'd14);
            3'd6: r.c = (w.c ^ w.b) - rotl32(w.b, 5'd24);
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/lookup3_byte_key_hash.sv -----
`timescale 1ns / 1ps
// top level of the lookup3 (hashlittle) byte-serial key hash
//
// Computes the 32-bit lookup3 little-endian hash of a key fed one byte per
// beat. The start beat loads a, b and c with 0xdeadbeef + key_length + seed;
// the end beat yields hash_value. The front end takes one key beat every
// cycle while the command queue has room and packs bytes into 12-byte
// blocks; it sends the back end one command per completed block that is
// followed by more bytes, and one per key end. The back end runs the block
// mix and the final mix one step per cycle on its a/b/c registers: a block
// command adds the block to a, b and c and then runs the six mix steps, a
// key end adds the block, runs the seven final steps and loads the output
// register, with the six mix steps first when a full block and one trailing
// byte close the key, and an empty key only adds and loads the output
// register. Bytes stream at one per cycle for keys of 9 to 12 bytes and of
// 16 bytes or more while each hash is taken; for keys of 13 to 15 and of
// under 9 bytes the back end lags and the QUEUE_DEPTH-entry queue fills.
// The result sits in an output register, so the back end keeps working
// while a hash waits to be taken, until it has its next hash to emit.

module lookup3_byte_key_hash #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // key beats
    input  logic        key_valid,
    output logic        key_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        start_of_key,
    input  logic        end_of_key,
    input  logic [15:0] key_length,
    input  logic [31:0] seed,
    // hash beats
    output logic        hash_valid,
    input  logic        hash_ready,
    output logic [31:0] hash_value
);

    localparam int CMD_W = $bits(lkh_pkg::lkh_cmd_t);

    lkh_pkg::lkh_cmd_t  front_cmd;
    lkh_pkg::lkh_cmd_t  back_cmd;
    logic               front_valid;
    logic               front_ready;
    logic               back_valid;
    logic               back_ready;
    logic [CMD_W-1:0]   push_bits;
    logic [CMD_W-1:0]   pop_bits;

    // gather bytes and classify each beat into block / end commands
    lkh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_ready    (key_ready),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .start_of_key (start_of_key),
        .end_of_key   (end_of_key),
        .key_length   (key_length),
        .seed         (seed),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready),
        .cmd          (front_cmd)
    );

    assign push_bits = front_cmd;
    assign back_cmd  = lkh_pkg::lkh_cmd_t'(pop_bits);

    // decouples byte gathering from the multi-cycle mixes
    lkh_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (push_bits),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (pop_bits)
    );

    // hash word state, mix sequencer and output register
    lkh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .cmd        (back_cmd),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_value (hash_value)
    );

endmodule

// ----- rtl/lkh_front.sv -----
`timescale 1ns / 1ps
// front end: takes key beats, packs 12-byte blocks and issues back end commands
module lkh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               key_valid,
    output logic               key_ready,
    input  logic [7:0]         data_byte,
    input  logic               byte_valid,
    input  logic               start_of_key,
    input  logic               end_of_key,
    input  logic [15:0]        key_length,
    input  logic [31:0]        seed,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output lkh_pkg::lkh_cmd_t  cmd
);

    logic [3:0]        pos_reg, pos_next;
    logic [11:0][7:0]  blk_reg, blk_next;
    logic              init_pend_reg, init_pend_next;
    logic [31:0]       init_val_reg, init_val_next;

    logic              accept;
    logic [31:0]       len_ext;
    logic [31:0]       len_clamped;
    logic [31:0]       start_value;
    logic [3:0]        eff_pos;
    logic [11:0][7:0]  eff_blk;
    logic [11:0][7:0]  ins_blk;
    logic [3:0]        ins_pos;
    logic              eff_init;
    logic [31:0]       eff_value;
    logic              full;
    logic [11:0][7:0]  cmd_blk;

    assign key_ready = cmd_ready;
    assign accept    = key_valid && key_ready;

    assign len_ext     = {16'd0, key_length};
    assign len_clamped = (len_ext > lkh_pkg::MAX_KEY_BYTES) ? lkh_pkg::MAX_KEY_BYTES : len_ext;
    assign start_value = lkh_pkg::HASH_INIT + len_clamped + seed;

    always_comb
    begin
        // a start drops whatever was gathered
        eff_pos   = start_of_key ? 4'd0 : pos_reg;
        eff_blk   = start_of_key ? '0 : blk_reg;
        eff_init  = start_of_key || init_pend_reg;
        eff_value = start_of_key ? start_value : init_val_reg;
        full      = (eff_pos == lkh_pkg::BLOCK_BYTES);

        ins_pos          = full ? 4'd0 : eff_pos;
        ins_blk          = full ? '0 : eff_blk;
        ins_blk[ins_pos] = data_byte;

        cmd_blk        = (byte_valid && !full) ? ins_blk : eff_blk;
        cmd.init       = eff_init;
        cmd.init_value = eff_value;
        cmd.k_a        = cmd_blk[3:0];
        cmd.k_b        = cmd_blk[7:4];
        cmd.k_c        = cmd_blk[11:8];
        cmd.mix        = byte_valid && full;
        cmd.tail_byte  = (byte_valid && full && end_of_key) ? data_byte : 8'd0;
        cmd.fin        = end_of_key && (byte_valid || (eff_pos != 4'd0));
        cmd.emit       = end_of_key;
        cmd_valid      = key_valid && (end_of_key || (byte_valid && full));

        pos_next       = pos_reg;
        blk_next       = blk_reg;
        init_pend_next = init_pend_reg;
        init_val_next  = init_val_reg;
        if (accept)
        begin
            init_val_next = eff_value;
            priority if (end_of_key)
            begin
                pos_next       = 4'd0;
                blk_next       = '0;
                init_pend_next = 1'b0;
            end
            else if (byte_valid && full)
            begin
                pos_next       = 4'd1;
                blk_next       = ins_blk;
                init_pend_next = 1'b0;
            end
            else if (byte_valid)
            begin
                pos_next       = eff_pos + 4'd1;
                blk_next       = ins_blk;
                init_pend_next = eff_init;
            end
            else
            begin
                pos_next       = eff_pos;
                blk_next       = eff_blk;
                init_pend_next = eff_init;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 4'd0;
            blk_reg       <= '0;
            init_pend_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            blk_reg       <= blk_next;
            init_pend_reg <= init_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        init_val_reg <= init_val_next;
    end

endmodule

// ----- rtl/lkh_cmd_fifo.sv -----
`timescale 1ns / 1ps
// small flop-based command queue between front and back end
module lkh_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/lkh_back.sv -----
`timescale 1ns / 1ps
// back end: holds the hash words, runs block and final mixes one step a cycle
module lkh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lkh_pkg::lkh_cmd_t  cmd,
    output logic               hash_valid,
    input  logic               hash_ready,
    output logic [31:0]        hash_value
);

    lkh_pkg::lkh_state_t state_reg, state_next;
    lkh_pkg::lkh_words_t words_reg, words_next;
    lkh_pkg::lkh_words_t base;
    lkh_pkg::lkh_words_t stepped;
    logic [2:0]          step_reg, step_next;
    logic                fin_reg, fin_next;
    logic                emit_reg, emit_next;
    logic [7:0]          tail_reg, tail_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         hash_reg, hash_next;
    logic                out_free;

    assign hash_valid = out_valid_reg;
    assign hash_value = hash_reg;
    assign out_free   = !out_valid_reg || hash_ready;

    always_comb
    begin
        state_next     = state_reg;
        words_next     = words_reg;
        step_next      = step_reg;
        fin_next       = fin_reg;
        emit_next      = emit_reg;
        tail_next      = tail_reg;
        out_valid_next = out_valid_reg && !hash_ready;
        hash_next      = hash_reg;
        cmd_ready      = 1'b0;
        base           = cmd.init ? {cmd.init_value, cmd.init_value, cmd.init_value}
                                  : words_reg;
        stepped        = words_reg;

        unique case (state_reg)
            lkh_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    // load the start words on an init command, and add in the block
                    words_next.a = base.a + cmd.k_a;
                    words_next.b = base.b + cmd.k_b;
                    words_next.c = base.c + cmd.k_c;
                    step_next    = 3'd0;
                    fin_next     = cmd.fin;
                    emit_next    = cmd.emit;
                    tail_next    = cmd.tail_byte;
                    priority if (cmd.mix)
                        state_next = lkh_pkg::ST_MIX;
                    else if (cmd.fin)
                        state_next = lkh_pkg::ST_FIN;
                    else if (cmd.emit)
                        state_next = lkh_pkg::ST_EMIT;
                    else
                        state_next = lkh_pkg::ST_IDLE;
                end
            end
            lkh_pkg::ST_MIX:
            begin
                stepped    = lkh_pkg::mix_step(step_reg, words_reg);
                words_next = stepped;
                if (step_reg == lkh_pkg::MIX_LAST)
                begin
                    // last mix step leaves a alone, so the trailing byte goes in here
                    words_next.a = stepped.a + {24'd0, tail_reg};
                    step_next    = 3'd0;
                    priority if (fin_reg)
                        state_next = lkh_pkg::ST_FIN;
                    else if (emit_reg)
                        state_next = lkh_pkg::ST_EMIT;
                    else
                        state_next = lkh_pkg::ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            lkh_pkg::ST_FIN:
            begin
                stepped    = lkh_pkg::fin_step(step_reg, words_reg);
                words_next = stepped;
                if (step_reg == lkh_pkg::FIN_LAST)
                begin
                    step_next  = 3'd0;
                    state_next = lkh_pkg::ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            lkh_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = words_reg.c;
                    state_next     = lkh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkh_pkg::ST_IDLE;
            words_reg     <= '0;
            step_reg      <= 3'd0;
            fin_reg       <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            words_reg     <= words_next;
            step_reg      <= step_next;
            fin_reg       <= fin_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        hash_reg <= hash_next;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the lookup3 byte-serial key hash

module tb_top;

    // one key beat as the sender sees it
    typedef struct packed {
        logic [7:0]  data;
        logic        has_byte;
        logic        first;
        logic        last;
        logic [15:0] len;
        logic [31:0] seed;
    } key_beat_t;

    localparam int     TAIL_CYCLES = 40;          // longer than the longest back-end job
    localparam int     HOLD_CYCLES = 300;
    localparam longint RUN_LIMIT_NS = 64'd5_000_000;

    logic        clk;
    logic        rst_n;
    logic        key_valid;
    logic        key_ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        start_of_key;
    logic        end_of_key;
    logic [15:0] key_length;
    logic [31:0] seed;
    logic        hash_valid;
    logic        hash_ready;
    logic [31:0] hash_value;

    // hash words and block progress of the predictor
    logic [31:0] ph_a;
    logic [31:0] ph_b;
    logic [31:0] ph_c;
    int unsigned ph_fill;
    bit          ph_full;

    logic [31:0] hash_expect[$];  // predicted hashes, oldest first
    int          err_count;
    int          items_sent;      // beats that start, end or carry a byte
    int          src_idle_pct;    // sender idle chance per cycle
    int          sink_stall_pct;  // receiver stall chance per cycle
    int          hold_left;       // cycles of forced receiver hold-off still to run
    event        hold_go;         // kicks off one long receiver hold-off

    lookup3_byte_key_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_ready    (key_ready),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .start_of_key (start_of_key),
        .end_of_key   (end_of_key),
        .key_length   (key_length),
        .seed         (seed),
        .hash_valid   (hash_valid),
        .hash_ready   (hash_ready),
        .hash_value   (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] rot_l(input logic [31:0] x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // six-step block mix, run on a full block that has more bytes after it
    function automatic void lk_block_mix();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = ph_a;
        b = ph_b;
        c = ph_c;
        a = (a - c) ^ rot_l(c, 4);  c = c + b;
        b = (b - a) ^ rot_l(a, 6);  a = a + c;
        c = (c - b) ^ rot_l(b, 8);  b = b + a;
        a = (a - c) ^ rot_l(c, 16); c = c + b;
        b = (b - a) ^ rot_l(a, 19); a = a + c;
        c = (c - b) ^ rot_l(b, 4);  b = b + a;
        ph_a = a;
        ph_b = b;
        ph_c = c;
    endfunction

    // seven-step final avalanche
    function automatic void lk_final_mix();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = ph_a;
        b = ph_b;
        c = ph_c;
        c = (c ^ b) - rot_l(b, 14);
        a = (a ^ c) - rot_l(c, 11);
        b = (b ^ a) - rot_l(a, 25);
        c = (c ^ b) - rot_l(b, 16);
        a = (a ^ c) - rot_l(c, 4);
        b = (b ^ a) - rot_l(a, 14);
        c = (c ^ b) - rot_l(b, 24);
        ph_a = a;
        ph_b = b;
        ph_c = c;
    endfunction

    function automatic void hash_state_clear();
        ph_a = '0;
        ph_b = '0;
        ph_c = '0;
        ph_fill = 0;
        ph_full = 1'b0;
    endfunction

    // applies one accepted key beat; a beat with an end yields one hash
    function automatic void hash_predict_beat(input key_beat_t bt, output bit emits,
                                              output logic [31:0] hv);
        logic [31:0] len_c;
        logic [31:0] init;
        logic [31:0] lane;
        emits = 1'b0;
        hv = '0;
        if (bt.first)
        begin
            len_c = 32'(bt.len);
            if (len_c > lkh_pkg::MAX_KEY_BYTES)
                len_c = lkh_pkg::MAX_KEY_BYTES;
            init = lkh_pkg::HASH_INIT + len_c + bt.seed;
            ph_a = init;
            ph_b = init;
            ph_c = init;
            ph_fill = 0;
            ph_full = 1'b0;
        end
        if (bt.has_byte)
        begin
            // a full block only gets mixed once a further byte shows up
            if (ph_full || ph_fill >= lkh_pkg::BLOCK_BYTES)
            begin
                lk_block_mix();
                ph_fill = 0;
                ph_full = 1'b0;
            end
            lane = 32'(bt.data) << (8 * (ph_fill % 4));
            if (ph_fill < 4)
                ph_a = ph_a + lane;
            else if (ph_fill < 8)
                ph_b = ph_b + lane;
            else
                ph_c = ph_c + lane;
            ph_fill = ph_fill + 1;
            if (ph_fill == lkh_pkg::BLOCK_BYTES)
                ph_full = 1'b1;
        end
        if (bt.last)
        begin
            // empty key: c goes out untouched
            if (ph_fill != 0 || ph_full)
                lk_final_mix();
            hv = ph_c;
            emits = 1'b1;
            ph_fill = 0;
            ph_full = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // hash side: random stall, forced hold-off, compare against oldest
    // ------------------------------------------------------------------

    // counts down the long hold-off on its own
    initial
    begin
        hold_left = 0;
        forever
        begin
            @(hold_go);
            hold_left = HOLD_CYCLES;
            while (hold_left != 0)
            begin
                @(posedge clk);
                hold_left = hold_left - 1;
            end
        end
    end

    initial
    begin
        hash_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && hash_valid && hash_ready)
            begin
                if (hash_expect.size() == 0)
                begin
                    $display("%0t: hash beat with none expected: expected none actual %08h",
                             $time, hash_value);
                    err_count++;
                end
                else
                begin
                    if (hash_value !== hash_expect[0])
                    begin
                        $display("%0t: hash_value mismatch: expected %08h actual %08h",
                                 $time, hash_expect[0], hash_value);
                        err_count++;
                    end
                    void'(hash_expect.pop_front());
                end
            end
            if (hold_left != 0)
                hash_ready <= 1'b0;
            else
                hash_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // key side
    // ------------------------------------------------------------------

    function automatic key_beat_t key_beat(input logic [7:0] d, input logic v,
                                           input logic f, input logic l,
                                           input logic [15:0] n, input logic [31:0] s);
        key_beat_t bt;
        bt.data = d;
        bt.has_byte = v;
        bt.first = f;
        bt.last = l;
        bt.len = n;
        bt.seed = s;
        return bt;
    endfunction

    // offers one beat, holds it until taken, then predicts on it
    task automatic send_beat(input key_beat_t bt);
        bit          emits;
        logic [31:0] hv;
        while ($urandom_range(99) < src_idle_pct)
        begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_valid    <= 1'b1;
        data_byte    <= bt.data;
        byte_valid   <= bt.has_byte;
        start_of_key <= bt.first;
        end_of_key   <= bt.last;
        key_length   <= bt.len;
        seed         <= bt.seed;
        @(posedge clk);
        while (!key_ready)
            @(posedge clk);
        hash_predict_beat(bt, emits, hv);
        if (emits)
            hash_expect.push_back(hv);
        if (bt.has_byte || bt.first || bt.last)
            items_sent++;
    endtask

    // sender stops and waits for every predicted hash to come back
    task automatic wait_drained();
        key_valid <= 1'b0;
        do
            @(posedge clk);
        while (hash_expect.size() != 0);
    endtask

    // one key with random content; a few are deliberately malformed
    task automatic send_random_key(input int max_bytes);
        int          nbytes;
        int          pick;
        bit          first_pending;
        bit          split_end;
        bit          drop_end;
        logic [15:0] len_f;
        logic [31:0] sd;
        pick = $urandom_range(99);
        if (pick < 55 || max_bytes <= 12)
            nbytes = $urandom_range((max_bytes < 12) ? max_bytes : 12);
        else if (pick < 90)
            nbytes = $urandom_range(40, 13);
        else
            nbytes = $urandom_range(max_bytes, 41);
        pick = $urandom_range(99);
        if (pick < 80)
            len_f = 16'(nbytes);
        else if (pick < 85)
            len_f = 16'hffff;
        else
            len_f = 16'($urandom_range(65535));
        sd = $urandom;
        first_pending = ($urandom_range(99) >= 6);   // missing start now and then
        split_end = ($urandom_range(99) < 15);
        drop_end = ($urandom_range(99) < 4);         // abandoned key, next start wipes it
        // start on a beat of its own, no byte with it
        if (first_pending && $urandom_range(99) < 15)
        begin
            send_beat(key_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, len_f, sd));
            first_pending = 1'b0;
        end
        for (int i = 0; i < nbytes; i++)
        begin
            // noise: beat with no byte, no start and no end
            if ($urandom_range(99) < 4)
                send_beat(key_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0,
                                   16'($urandom_range(65535)), $urandom));
            send_beat(key_beat(8'($urandom_range(255)), 1'b1, first_pending,
                               (i == nbytes - 1) && !split_end && !drop_end, len_f, sd));
            first_pending = 1'b0;
        end
        if ((nbytes == 0 || split_end) && !drop_end)
            send_beat(key_beat(8'($urandom_range(255)), 1'b0, first_pending, 1'b1, len_f, sd));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // empty key: initial c goes straight out
        send_beat(key_beat(8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 32'h0000_0000));
        // start, byte and end on one beat, every field at its top
        send_beat(key_beat(8'hff, 1'b1, 1'b1, 1'b1, 16'hffff, 32'hffff_ffff));
        // exactly one block: only the final mix, the pending block mix is dropped
        for (int i = 0; i < 12; i++)
            send_beat(key_beat((i % 2) ? 8'hff : 8'h00, 1'b1, i == 0, i == 11,
                               16'd12, 32'h8000_0001));
        // no start: keeps hashing on the words the previous key left
        send_beat(key_beat(8'h5a, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0000));
        send_beat(key_beat(8'ha5, 1'b1, 1'b0, 1'b1, 16'h0000, 32'h0000_0000));
        // start alone, one byte, an ignored beat, end alone; length does not match
        send_beat(key_beat(8'h00, 1'b0, 1'b1, 1'b0, 16'd7, 32'h1234_5678));
        send_beat(key_beat(8'h80, 1'b1, 1'b0, 1'b0, 16'hffff, 32'hffff_ffff));
        send_beat(key_beat(8'hff, 1'b0, 1'b0, 1'b0, 16'hffff, 32'hffff_ffff));
        send_beat(key_beat(8'h01, 1'b0, 1'b0, 1'b1, 16'hffff, 32'hffff_ffff));
        wait_drained();
    endtask

    task automatic test_random_keys(input int src_pct, input int sink_pct, input int n_items);
        int target;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        target = items_sent + n_items;
        while (items_sent < target)
            send_random_key(100);
        wait_drained();
    endtask

    // receiver holds off for a long stretch while short keys keep coming,
    // so the command queue fills and key_ready drops
    task automatic test_backpressure();
        int target;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        -> hold_go;
        target = items_sent + 150;
        while (items_sent < target)
            send_random_key(3);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial
    begin
        err_count = 0;
        items_sent = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hash_state_clear();
        rst_n        <= 1'b0;
        key_valid    <= 1'b0;
        data_byte    <= '0;
        byte_valid   <= 1'b0;
        start_of_key <= 1'b0;
        end_of_key   <= 1'b0;
        key_length   <= '0;
        seed         <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_keys(0, 0, 320);     // no idling
        test_random_keys(72, 0, 320);    // sender mostly idle
        test_random_keys(0, 72, 320);    // receiver mostly stalled
        test_random_keys(20, 20, 320);   // both, lightly
        test_backpressure();

        // stray hashes would show up in this window
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
